/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge, reset low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/fsw_pkg.sv */
// ----------------------------------------------------------------------------
// fsw_pkg
// constants, tables and controller/datapath types of the square wave synthesizer
// ----------------------------------------------------------------------------
package fsw_pkg;

    localparam int MAX_GROUPS      = 16;
    localparam int SINE_TABLE_BITS = 10;

    localparam int MAX_HARM  = MAX_GROUPS * 4;
    localparam int HARM_W    = $clog2(MAX_HARM + 1);
    localparam int KIDX_W    = $clog2(MAX_HARM);
    localparam int QTR_BITS  = SINE_TABLE_BITS - 2;
    localparam int QTR_LEN   = 1 << QTR_BITS;
    localparam int QIDX_W    = QTR_BITS + 1;
    localparam int ACC_W     = 40;
    localparam int SCALED_W  = ACC_W + 16;

    localparam int AMP_W     = 16;
    localparam int FREQ_W    = 32;
    localparam int GROUPS_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS    = 2'd2;

    localparam logic signed [AMP_W-1:0] AMP_RESET    = 16'sd256;
    localparam logic [FREQ_W-1:0]       FREQ_RESET   = 32'd65536;
    localparam logic [GROUPS_W-1:0]     GROUPS_RESET = 5'd4;

    localparam longint TWO_OVER_PI_Q30 = 64'sd683565276;
    localparam longint HALF_Q30        = 64'sd536870912;
    localparam longint POLY_A1         = 64'sd1686629713;
    localparam longint POLY_A3         = 64'sd693598668;
    localparam longint POLY_A5         = 64'sd85569306;
    localparam longint POLY_A7         = 64'sd5026995;
    localparam longint POLY_A9         = 64'sd172272;

    typedef logic [QTR_LEN:0][31:0]     t_sine_rom;
    typedef logic [MAX_HARM-1:0][29:0]  t_coef_rom;

    // quarter-wave sine, Q1.30, one entry per quantized angle from 0 to pi/2
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    x;
        longint    x2;
        longint    p;
        for (int i = 0; i <= QTR_LEN; i++) begin
            x  = longint'(i) << (30 - QTR_BITS);
            x2 = (x * x) >>> 30;
            p  = ((POLY_A9 * x2) >>> 30) - POLY_A7;
            p  = ((p * x2) >>> 30) + POLY_A5;
            p  = ((p * x2) >>> 30) - POLY_A3;
            p  = ((p * x2) >>> 30) + POLY_A1;
            p  = (p * x) >>> 30;
            rom[i] = p[31:0];
        end
        return rom;
    endfunction

    // 2/(h*pi) in unsigned Q0.30 for odd h, rounded, by shift and subtract long division
    function automatic t_coef_rom build_coef_rom();
        t_coef_rom rom;
        longint    h;
        longint    num;
        longint    rem;
        longint    c;
        for (int i = 0; i < MAX_HARM; i++) begin
            h   = 2 * longint'(i) + 1;
            num = TWO_OVER_PI_Q30 + (h >>> 1);
            rem = 0;
            c   = 0;
            for (int b = 31; b >= 0; b--) begin
                rem = (rem << 1) | ((num >>> b) & 64'sd1);
                c   = c << 1;
                if (rem >= h) begin
                    rem = rem - h;
                    c   = c | 64'sd1;
                end
            end
            rom[i] = c[29:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam t_coef_rom COEF_ROM = build_coef_rom();

    typedef struct packed {
        logic load_time;
        logic load_phase;
        logic issue;
        logic scale;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic no_harm;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PHASE = 6'b000010,
        S_RUN   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_SCALE = 6'b010000,
        S_ROUND = 6'b100000
    } t_state;

endpackage

/* rtl/fsw_ctrl.sv */
// ----------------------------------------------------------------------------
// fsw_ctrl
// sequencer: takes a request, steps the harmonics, drains, scales and emits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  fsw_pkg::t_status i_status,
    output fsw_pkg::t_cmd    o_cmd
);
    import fsw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load_time = 1'b1;
                    n_state         = S_PHASE;
                end
            end
            S_PHASE: begin
                o_cmd.load_phase = 1'b1;
                n_state = i_status.no_harm ? S_DRAIN : S_RUN;
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // accumulator must be settled before it is scaled
    `ASSERT_IMPLIES(a_scale_after_drain, i_clk, i_rst_n, o_cmd.scale, !i_status.pipe_busy)
    // a harmonic is issued only when there is one to issue
    `ASSERT_IMPLIES(a_issue_has_harm, i_clk, i_rst_n, o_cmd.issue, !i_status.no_harm)
    // the last harmonic is followed by the drain wait
    `ASSERT_NEXT(a_last_then_drain, i_clk, i_rst_n,
                 o_cmd.issue && i_status.last_issue, r_state == S_DRAIN)

endmodule

/* rtl/fsw_dp.sv */
// ----------------------------------------------------------------------------
// fsw_dp
// datapath: config registers, phase multiply, harmonic sine/coef pipeline,
// accumulator, amplitude scaling and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsw_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fsw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fsw_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    input  logic [31:0]                       i_time_req,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic signed [31:0]                o_sample,
    input  fsw_pkg::t_cmd                     i_cmd,
    output fsw_pkg::t_status                  o_status
);
    import fsw_pkg::*;

    // configuration
    logic signed [AMP_W-1:0] r_amp;
    logic [FREQ_W-1:0]       r_freq;
    logic [GROUPS_W-1:0]     r_groups;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp    <= AMP_RESET;
            r_freq   <= FREQ_RESET;
            r_groups <= GROUPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AMPLITUDE: r_amp    <= $signed(i_cfg_wdata[AMP_W-1:0]);
                CFG_FREQUENCY: r_freq   <= i_cfg_wdata[FREQ_W-1:0];
                CFG_GROUPS:    r_groups <= i_cfg_wdata[GROUPS_W-1:0];
                default: ;
            endcase
        end
    end

    // harmonic count, groups clipped to the maximum
    logic [HARM_W-1:0] w_nharm;
    always_comb begin
        if (HARM_W'(r_groups) > HARM_W'(MAX_GROUPS)) begin
            w_nharm = HARM_W'(MAX_HARM);
        end else begin
            w_nharm = HARM_W'(r_groups) << 2;
        end
    end

    // time and phase
    logic [31:0]       r_time;
    logic [31:0]       r_phase;
    logic [31:0]       r_hphase;
    logic [HARM_W-1:0] r_k;
    logic [31:0]       w_phase;

    assign w_phase = 32'(r_freq * r_time);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_time) begin
            r_time <= i_time_req;
        end
        if (i_cmd.load_phase) begin
            r_phase  <= w_phase;
            r_hphase <= w_phase;
        end else if (i_cmd.issue) begin
            // next odd harmonic adds twice the fundamental phase
            r_hphase <= r_hphase + {r_phase[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.load_phase) begin
            r_k <= '0;
        end else if (i_cmd.issue) begin
            r_k <= r_k + 1'b1;
        end
    end

    // stage a: table lookups
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]                 w_quad;
    logic [QTR_BITS-1:0]        w_rem;
    logic [QIDX_W-1:0]          w_qidx;
    logic signed [31:0]         w_entry;
    logic signed [31:0]         w_sine;

    assign w_idx   = r_hphase[31 -: SINE_TABLE_BITS];
    assign w_quad  = w_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_rem   = w_idx[QTR_BITS-1:0];
    assign w_qidx  = w_quad[0] ? (QIDX_W'(QTR_LEN) - {1'b0, w_rem}) : {1'b0, w_rem};
    assign w_entry = $signed(SINE_ROM[w_qidx]);
    assign w_sine  = w_quad[1] ? -w_entry : w_entry;

    logic               r_va;
    logic               r_vb;
    logic signed [31:0] r_sine;
    logic [29:0]        r_coef;
    logic signed [62:0] r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_cmd.issue;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_sine <= w_sine;
            r_coef <= COEF_ROM[r_k[KIDX_W-1:0]];
        end
        // stage b: sine times coefficient
        if (r_va) begin
            r_term <= r_sine * $signed({1'b0, r_coef});
        end
    end

    // stage c: accumulate, then scale by amplitude
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SCALED_W-1:0] r_scaled;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_phase) begin
            r_acc <= ACC_W'(HALF_Q30);
        end else if (r_vb) begin
            r_acc <= r_acc + ACC_W'(r_term >>> 30);
        end
        if (i_cmd.scale) begin
            r_scaled <= r_acc * r_amp;
        end
    end

    // round half up to Q15.16 and saturate
    logic signed [SCALED_W-1:0] w_rnd;
    logic signed [31:0]         w_sat;

    assign w_rnd = (r_scaled + SCALED_W'(64'sd2097152)) >>> 22;

    always_comb begin
        if (w_rnd > SCALED_W'(64'sd2147483647)) begin
            w_sat = 32'sh7fff_ffff;
        end else if (w_rnd < -SCALED_W'(64'sd2147483648)) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_rnd[31:0];
        end
    end

    // output register
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_sample <= w_sat;
        end
    end

    assign o_valid = r_valid;

    assign o_status.no_harm    = (w_nharm == '0);
    assign o_status.last_issue = ((r_k + 1'b1) == w_nharm);
    assign o_status.pipe_busy  = r_va || r_vb;
    assign o_status.out_free   = !r_valid || !i_stall;

    // the output register is loaded only when its old result is gone
    `ASSERT_IMPLIES(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_valid || !i_stall)
    // the harmonic counter stays within the configured count
    `ASSERT_IMPLIES(a_k_range, i_clk, i_rst_n, i_cmd.issue, r_k < w_nharm)
    // a stalled result stays offered
    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, r_valid && i_stall, r_valid)

endmodule

/* rtl/fourier_square_wave_sample.sv */
// ----------------------------------------------------------------------------
// fourier_square_wave_sample
// band-limited square wave sample from a Fourier series of odd harmonics
// ----------------------------------------------------------------------------
// One request (a Q16.16 time) gives one Q15.16 sample. The block works on one
// request at a time: for G harmonic groups (G clipped to 16), a harmonic loop
// pushes one odd harmonic per cycle, 4*G of them, through a shared sine-table,
// coefficient multiply and accumulate pipeline, after a phase multiply step
// and before drain, amplitude scaling and rounding steps. A finished sample
// sits in an output register, so it may wait on a stall while the next
// request is already being worked on. Configuration writes take effect at
// once and belong between requests.
// ----------------------------------------------------------------------------
module fourier_square_wave_sample (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fsw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fsw_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_time_req,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_sample
);
    import fsw_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    fsw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fsw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_time_req  (i_time_req),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_sample    (o_sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
